// ----- hdl/trc_pkg.sv -----
// ----------------------------------------------------------------------------
// trc_pkg: shared types, constants and helpers of the typed relational compare
// Operator and type codes, the default equality tolerance, the stage control
// struct, a leading-zero counter and the final relation decode.
// ----------------------------------------------------------------------------
package trc_pkg;

  typedef enum logic [2:0] {
    KIND_EQ = 3'd0,
    KIND_GT = 3'd1,
    KIND_GE = 3'd2,
    KIND_LT = 3'd3,
    KIND_LE = 3'd4,
    KIND_NE = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    TYPE_I64   = 2'd0,
    TYPE_DBL   = 2'd1,
    TYPE_OTHER = 2'd2
  } type_e;

  localparam logic [63:0] EPSILON_RESET = 64'h3EB0_C6F7_A0B5_ED8D;
  localparam logic [63:0] SIGN64        = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [2:0] kind;
    logic       err;
    logic       is_dbl;
  } ctl_t;

  // Six halving steps; a zero word returns 63.
  function automatic logic [5:0] lzc64(logic [63:0] x);
    logic [5:0]  n;
    logic [63:0] v;
    n = 6'd0;
    v = x;
    if (v[63:32] == 32'd0) begin n[5] = 1'b1; v = v << 32; end
    if (v[63:48] == 16'd0) begin n[4] = 1'b1; v = v << 16; end
    if (v[63:56] == 8'd0)  begin n[3] = 1'b1; v = v << 8;  end
    if (v[63:60] == 4'd0)  begin n[2] = 1'b1; v = v << 4;  end
    if (v[63:62] == 2'd0)  begin n[1] = 1'b1; v = v << 2;  end
    if (v[63] == 1'b0)     begin n[0] = 1'b1; end
    return n;
  endfunction

  // lt and eq are already false for an unordered pair.
  function automatic logic rel_flag(logic [2:0] kind, logic lt, logic eq, logic unord,
                                    logic near, logic is_dbl);
    logic f;
    case (kind)
      KIND_EQ: f = is_dbl ? near : eq;
      KIND_NE: f = is_dbl ? !near : !eq;
      KIND_GT: f = !unord && !lt && !eq;
      KIND_GE: f = !unord && !lt;
      KIND_LT: f = lt;
      KIND_LE: f = lt || eq;
      default: f = 1'b0;
    endcase
    return f;
  endfunction

endpackage

// ----- hdl/trc_prep.sv -----
// ----------------------------------------------------------------------------
// trc_prep: operand conversion stages
// Truncates a double second operand to int64 and compares integers; rounds an
// integer second operand to double. Three register stages.
// ----------------------------------------------------------------------------
module trc_prep (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [1:0]  type_b_i,
  input  logic [63:0] value_a_i,
  input  logic [63:0] value_b_i,
  output logic [63:0] a_dbl_o,
  output logic [63:0] b_dbl_o,
  output logic        int_lt_o,
  output logic        int_eq_o
);

  // stage 1
  logic [1:0]  tb1_q;
  logic [63:0] va1_q, vb1_q;
  logic        bneg1_q;
  logic [63:0] bmag1_q, bmag1_d;
  logic [63:0] tm1_q, tm1_d;
  logic        ts1_q, ts1_d, tsat1_q, tsat1_d;
  // stage 2
  logic [1:0]  tb2_q;
  logic [63:0] va2_q, vb2_q, ib2_q, ib2_d;
  logic        bneg2_q, bz2_q;
  logic [5:0]  lz2_q, lz2_d;
  logic [63:0] norm2_q;
  // stage 3
  logic [63:0] a3_q, b3_q, b3_d;
  logic        lt3_q, eq3_q;

  logic [10:0] e_b, lsh, rsh;
  logic [63:0] m64, t_val;
  logic        up;
  logic [10:0] exp_i;
  logic [62:0] packed_i;

  always_comb begin
    bmag1_d = value_b_i[63] ? (~value_b_i + 64'd1) : value_b_i;
    e_b     = value_b_i[62:52];
    m64     = {11'd0, 1'b1, value_b_i[51:0]};
    lsh     = e_b - 11'd1075;
    rsh     = 11'd1075 - e_b;
    tm1_d   = 64'd0;
    tsat1_d = 1'b0;
    ts1_d   = value_b_i[63];
    if (e_b == 11'h7FF && value_b_i[51:0] != 52'd0) begin
      ts1_d = 1'b0;
    end else if (e_b >= 11'd1086) begin
      tsat1_d = 1'b1;
    end else if (e_b < 11'd1023) begin
      tm1_d = 64'd0;
    end else if (e_b >= 11'd1075) begin
      tm1_d = m64 << lsh[3:0];
    end else begin
      tm1_d = m64 >> rsh[5:0];
    end
  end

  always_comb begin
    if (tsat1_q) begin
      t_val = ts1_q ? trc_pkg::SIGN64 : ~trc_pkg::SIGN64;
    end else begin
      t_val = ts1_q ? (~tm1_q + 64'd1) : tm1_q;
    end
    ib2_d = (tb1_q == trc_pkg::TYPE_I64) ? vb1_q : t_val;
    lz2_d = trc_pkg::lzc64(bmag1_q);
  end

  always_comb begin
    up       = norm2_q[10] && ((|norm2_q[9:0]) || norm2_q[11]);
    exp_i    = 11'd1086 - {5'd0, lz2_q};
    packed_i = {exp_i, norm2_q[62:11]} + {62'd0, up};
    if (tb2_q == trc_pkg::TYPE_I64) begin
      b3_d = bz2_q ? 64'd0 : {bneg2_q, packed_i};
    end else begin
      b3_d = vb2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tb1_q   <= type_b_i;
      va1_q   <= value_a_i;
      vb1_q   <= value_b_i;
      bneg1_q <= value_b_i[63];
      bmag1_q <= bmag1_d;
      tm1_q   <= tm1_d;
      ts1_q   <= ts1_d;
      tsat1_q <= tsat1_d;

      tb2_q   <= tb1_q;
      va2_q   <= va1_q;
      vb2_q   <= vb1_q;
      ib2_q   <= ib2_d;
      bneg2_q <= bneg1_q;
      bz2_q   <= (bmag1_q == 64'd0);
      lz2_q   <= lz2_d;
      norm2_q <= bmag1_q << lz2_d;

      a3_q  <= va2_q;
      b3_q  <= b3_d;
      lt3_q <= $signed(va2_q) < $signed(ib2_q);
      eq3_q <= (va2_q == ib2_q);
    end
  end

  assign a_dbl_o  = a3_q;
  assign b_dbl_o  = b3_q;
  assign int_lt_o = lt3_q;
  assign int_eq_o = eq3_q;

endmodule

// ----- hdl/trc_fp_cmp.sv -----
// ----------------------------------------------------------------------------
// trc_fp_cmp: double compare and tolerance test
// Ordered compare of two doubles plus the rounded magnitude of a - b checked
// against epsilon. Four register stages: align, add, normalize, round.
// ----------------------------------------------------------------------------
module trc_fp_cmp (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic [63:0] eps_i,
  output logic        lt_o,
  output logic        eq_o,
  output logic        unord_o,
  output logic        near_o
);

  typedef struct packed {
    logic lt;
    logic eq;
    logic unord;
    logic nan_d;
    logic inf_d;
  } cmp_t;

  cmp_t        c1_q, c2_q, c3_q, c1_d;
  logic        lt4_q, eq4_q, unord4_q, near4_q;
  logic [55:0] mb1_q, ms1_q, mb1_d, ms1_d;
  logic        sub1_q;
  logic [10:0] eb1_q, eb2_q, eb1_d;
  logic [56:0] m2_q;
  logic [55:0] n3_q, n3_d;
  logic [10:0] ex3_q, ex3_d;

  logic        nan_a, nan_b, inf_a, inf_b, swap;
  logic [63:0] ka, kb, big, sml;
  logic [10:0] es, diff;
  logic [55:0] ms_full, ms_sh, lost;
  logic [5:0]  lz, sh;
  logic [10:0] lim;
  logic [62:0] mag;
  logic        up, eps_ok;

  // align
  always_comb begin
    nan_a = (a_i[62:52] == 11'h7FF) && (a_i[51:0] != 52'd0);
    nan_b = (b_i[62:52] == 11'h7FF) && (b_i[51:0] != 52'd0);
    inf_a = (a_i[62:52] == 11'h7FF) && (a_i[51:0] == 52'd0);
    inf_b = (b_i[62:52] == 11'h7FF) && (b_i[51:0] == 52'd0);
    ka = (a_i[62:0] == 63'd0) ? trc_pkg::SIGN64 : (a_i[63] ? ~a_i : a_i ^ trc_pkg::SIGN64);
    kb = (b_i[62:0] == 63'd0) ? trc_pkg::SIGN64 : (b_i[63] ? ~b_i : b_i ^ trc_pkg::SIGN64);
    c1_d.unord = nan_a || nan_b;
    c1_d.lt    = !c1_d.unord && (ka < kb);
    c1_d.eq    = !c1_d.unord && (ka == kb);
    c1_d.nan_d = c1_d.unord || (inf_a && inf_b && (a_i[63] == b_i[63]));
    c1_d.inf_d = inf_a || inf_b;

    swap    = a_i[62:0] < b_i[62:0];
    big     = swap ? b_i : a_i;
    sml     = swap ? a_i : b_i;
    eb1_d   = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
    es      = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
    diff    = eb1_d - es;
    mb1_d   = {(big[62:52] != 11'd0), big[51:0], 3'b000};
    ms_full = {(sml[62:52] != 11'd0), sml[51:0], 3'b000};
    if (diff >= 11'd56) begin
      ms_sh = 56'd0;
      lost  = ms_full;
    end else begin
      ms_sh = ms_full >> diff[5:0];
      lost  = ms_full & ~({56{1'b1}} << diff[5:0]);
    end
    ms1_d = {ms_sh[55:1], ms_sh[0] | (|lost)};
  end

  // normalize
  always_comb begin
    lz  = trc_pkg::lzc64({m2_q[55:0], 8'd0});
    lim = eb2_q - 11'd1;
    sh  = (lim < 11'd64 && {5'd0, lz} > lim) ? lim[5:0] : lz;
    if (m2_q[56]) begin
      n3_d  = {m2_q[56:2], m2_q[1] | m2_q[0]};
      ex3_d = eb2_q + 11'd1;
    end else begin
      n3_d  = m2_q[55:0] << sh;
      ex3_d = n3_d[55] ? (eb2_q - {5'd0, sh}) : 11'd0;
    end
  end

  // round, then test against the tolerance
  always_comb begin
    up = n3_q[2] && (n3_q[1] || n3_q[0] || n3_q[3]);
    if (c3_q.inf_d || ex3_q == 11'h7FF) begin
      mag = {11'h7FF, 52'd0};
    end else begin
      mag = {ex3_q, n3_q[54:3]} + {62'd0, up};
    end
    eps_ok = !((eps_i[62:52] == 11'h7FF) && (eps_i[51:0] != 52'd0)) &&
             (!eps_i[63] || eps_i[62:0] == 63'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q   <= c1_d;
      mb1_q  <= mb1_d;
      ms1_q  <= ms1_d;
      sub1_q <= (a_i[63] == b_i[63]);
      eb1_q  <= eb1_d;

      c2_q   <= c1_q;
      eb2_q  <= eb1_q;
      m2_q   <= sub1_q ? ({1'b0, mb1_q} - {1'b0, ms1_q}) : ({1'b0, mb1_q} + {1'b0, ms1_q});

      c3_q  <= c2_q;
      n3_q  <= n3_d;
      ex3_q <= ex3_d;

      lt4_q    <= c3_q.lt;
      eq4_q    <= c3_q.eq;
      unord4_q <= c3_q.unord;
      near4_q  <= !c3_q.nan_d && eps_ok && (mag <= eps_i[62:0]);
    end
  end

  assign lt_o    = lt4_q;
  assign eq_o    = eq4_q;
  assign unord_o = unord4_q;
  assign near_o  = near4_q;

endmodule

// ----- hdl/typed_relational_compare_core.sv -----
// ----------------------------------------------------------------------------
// typed_relational_compare_core: typed relational compare, top level
// Compares two tagged int64/double operands under one of six operators.
// ----------------------------------------------------------------------------
// One request enters per cycle unless a held result stalls the pipe; the
// pipeline is an input stage, three conversion stages (truncate or round the
// second operand, integer compare), four double stages (align, add,
// normalize, round and tolerance test) and the result register. A stall on
// the result side freezes every stage at once, so in_ready_o follows
// out_ready_i whenever a result is waiting. The user must write epsilon
// through cfg_we_i/cfg_wdata_i while no request is in flight; not enforced.
module typed_relational_compare_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [1:0]  type_a_i,
  input  logic [63:0] value_a_i,
  input  logic [1:0]  type_b_i,
  input  logic [63:0] value_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        flag_o,
  output logic        status_o
);

  localparam int NumStages = 9;
  localparam int LastCtl   = 7;

  logic [NumStages-1:0] valid_q;
  logic [63:0]          eps_q;
  logic                 adv;

  trc_pkg::ctl_t ctl_d;
  trc_pkg::ctl_t ctl_q [LastCtl+1];
  logic [1:0]    tb0_q;
  logic [63:0]   va0_q, vb0_q;

  logic [63:0] a_dbl, b_dbl;
  logic        int_lt, int_eq;
  logic [3:0]  ilt_q, ieq_q;
  logic        d_lt, d_eq, d_unord, d_near;
  logic        flag_q, status_q, flag_d;

  // Advance the whole pipe unless a finished result is held.
  assign adv        = !valid_q[NumStages-1] || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    ctl_d.kind   = kind_i;
    ctl_d.err    = (kind_i > trc_pkg::KIND_NE) || (type_a_i > trc_pkg::TYPE_DBL) ||
                   (type_b_i > trc_pkg::TYPE_DBL);
    ctl_d.is_dbl = (type_a_i == trc_pkg::TYPE_DBL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      eps_q   <= trc_pkg::EPSILON_RESET;
    end else begin
      if (adv) begin
        valid_q <= {valid_q[NumStages-2:0], in_valid_i};
      end
      if (cfg_we_i) begin
        eps_q <= cfg_wdata_i;
      end
    end
  end

  // Payload stages: no reset, hold on stall.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl_q[0] <= ctl_d;
      for (int i = 1; i <= LastCtl; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
      tb0_q <= type_b_i;
      va0_q <= value_a_i;
      vb0_q <= value_b_i;
      ilt_q <= {ilt_q[2:0], int_lt};
      ieq_q <= {ieq_q[2:0], int_eq};
      flag_q   <= flag_d;
      status_q <= ctl_q[LastCtl].err;
    end
  end

  trc_prep u_prep (
    .clk_i     (clk_i),
    .en_i      (adv),
    .type_b_i  (tb0_q),
    .value_a_i (va0_q),
    .value_b_i (vb0_q),
    .a_dbl_o   (a_dbl),
    .b_dbl_o   (b_dbl),
    .int_lt_o  (int_lt),
    .int_eq_o  (int_eq)
  );

  trc_fp_cmp u_fp_cmp (
    .clk_i   (clk_i),
    .en_i    (adv),
    .a_i     (a_dbl),
    .b_i     (b_dbl),
    .eps_i   (eps_q),
    .lt_o    (d_lt),
    .eq_o    (d_eq),
    .unord_o (d_unord),
    .near_o  (d_near)
  );

  // Pick the integer or double verdict; drop it on an error.
  always_comb begin
    if (ctl_q[LastCtl].err) begin
      flag_d = 1'b0;
    end else if (ctl_q[LastCtl].is_dbl) begin
      flag_d = trc_pkg::rel_flag(ctl_q[LastCtl].kind, d_lt, d_eq, d_unord, d_near, 1'b1);
    end else begin
      flag_d = trc_pkg::rel_flag(ctl_q[LastCtl].kind, ilt_q[3], ieq_q[3], 1'b0, 1'b0, 1'b0);
    end
  end

  assign out_valid_o = valid_q[NumStages-1];
  assign flag_o      = flag_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  a_err_clears_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> !flag_o)
    else $error("error status with a set flag");

  a_stall_freezes_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(valid_q))
    else $error("pipeline moved during a stall");
`endif

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for typed_relational_compare_core
// Drives directed and random compare requests over several tolerance settings
// and idle patterns, predicts every result and checks it in arrival order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam logic [63:0] DBL_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] DBL_INF = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] DBL_2P63 = 64'h43E0_0000_0000_0000;
  // Operator and type codes outside the supported set.
  localparam logic [2:0] KIND_BAD_A = 3'd6;
  localparam logic [2:0] KIND_BAD_B = 3'd7;
  localparam logic [1:0] TYPE_BAD   = 2'd3;

  typedef struct {
    logic flag;
    logic status;
  } cmp_result_t;

  // Scoreboard: predicts each accepted request and holds the results in order.
  class compare_scoreboard;
    cmp_result_t pending[$];
    logic [63:0] epsilon;
    int unsigned errors;
    int unsigned checked;

    function new();
      epsilon = trc_pkg::EPSILON_RESET;
      errors  = 0;
      checked = 0;
    endfunction

    // Truncate a double toward zero with saturation, working on the bits.
    function logic [63:0] trunc_to_int(logic [63:0] d);
      int          e;
      logic [63:0] mag;
      e = int'(d[62:52]) - 1023;
      if (d[62:52] == 11'h7FF && d[51:0] != 0) return 64'd0;
      if (e < 0) return 64'd0;
      if (e >= 63) return d[63] ? trc_pkg::SIGN64 : ~trc_pkg::SIGN64;
      mag = {11'd0, 1'b1, d[51:0]};
      mag = (e >= 52) ? (mag << (e - 52)) : (mag >> (52 - e));
      return d[63] ? -mag : mag;
    endfunction

    function void note(logic [2:0] kind, logic [1:0] ta, logic [63:0] va,
                       logic [1:0] tb, logic [63:0] vb);
      cmp_result_t r;
      logic [63:0] ia, ib;
      real         ra, rb, diff, eps;
      logic        near;
      r.flag   = 1'b0;
      r.status = 1'b0;
      if (kind > trc_pkg::KIND_NE || ta > trc_pkg::TYPE_DBL ||
          tb > trc_pkg::TYPE_DBL) begin
        r.status = 1'b1;
      end else if (ta == trc_pkg::TYPE_I64) begin
        // Bias the sign bit so an unsigned compare orders signed values.
        ia = va ^ trc_pkg::SIGN64;
        ib = ((tb == trc_pkg::TYPE_I64) ? vb : trunc_to_int(vb)) ^ trc_pkg::SIGN64;
        case (kind)
          trc_pkg::KIND_EQ: r.flag = (ia == ib);
          trc_pkg::KIND_GT: r.flag = (ia > ib);
          trc_pkg::KIND_GE: r.flag = (ia >= ib);
          trc_pkg::KIND_LT: r.flag = (ia < ib);
          trc_pkg::KIND_LE: r.flag = (ia <= ib);
          default: r.flag = (ia != ib);
        endcase
      end else begin
        ra = $bitstoreal(va);
        rb = (tb == trc_pkg::TYPE_I64) ? real'($signed(vb)) : $bitstoreal(vb);
        eps = $bitstoreal(epsilon);
        diff = ra - rb;
        near = (diff >= -eps) && (diff <= eps);
        case (kind)
          trc_pkg::KIND_EQ: r.flag = near;
          trc_pkg::KIND_GT: r.flag = (ra > rb);
          trc_pkg::KIND_GE: r.flag = (ra >= rb);
          trc_pkg::KIND_LT: r.flag = (ra < rb);
          trc_pkg::KIND_LE: r.flag = (ra <= rb);
          default: r.flag = !near;
        endcase
      end
      pending.push_back(r);
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check(logic flag, logic status);
      cmp_result_t r;
      if (pending.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        r = pending.pop_front();
        checked++;
        if (flag !== r.flag)
          report($sformatf("flag got %b want %b (result %0d)", flag, r.flag, checked));
        if (status !== r.status)
          report($sformatf("status got %b want %b (result %0d)", status, r.status, checked));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [63:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  kind_i = '0;
  logic [1:0]  type_a_i = '0;
  logic [63:0] value_a_i = '0;
  logic [1:0]  type_b_i = '0;
  logic [63:0] value_b_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        flag_o;
  logic        status_o;

  compare_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned sent = 0;

  typed_relational_compare_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .kind_i(kind_i), .type_a_i(type_a_i), .value_a_i(value_a_i),
    .type_b_i(type_b_i), .value_b_i(value_b_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .flag_o(flag_o), .status_o(status_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Sample both handshakes at the edge; inputs change only by NBA, so no race.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.note(kind_i, type_a_i, value_a_i, type_b_i, value_b_i);
      if (out_valid_o && out_ready_i)
        sb.check(flag_o, status_o);
    end
  end

  // Receiver: random stalls, or a long hold-off while hold_cycles runs down.
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one request; hold it until accepted. Valid stays high into the next
  // request unless the sender decides to idle.
  task send(logic [2:0] k, logic [1:0] ta, logic [63:0] va, logic [1:0] tb,
            logic [63:0] vb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    type_a_i   <= ta;
    value_a_i  <= va;
    type_b_i   <= tb;
    value_b_i  <= vb;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  // Drop valid, let the pipe drain, then write the tolerance.
  task write_epsilon(logic [63:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    sb.epsilon = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Operand bits: raw noise, small integers, doubles of small values, specials.
  function automatic logic [63:0] rand_operand(logic as_dbl);
    int unsigned sel;
    longint      si;
    sel = $urandom_range(9);
    si  = longint'($urandom_range(200)) - 100;
    case (sel)
      0, 1: return rand64();
      2: return as_dbl ? (DBL_NAN | {63'd0, 1'($urandom_range(1))}) : trc_pkg::SIGN64;
      3: return as_dbl ? (DBL_INF | {1'($urandom_range(1)), 63'd0}) : ~trc_pkg::SIGN64;
      4: return as_dbl ? (DBL_2P63 | {1'($urandom_range(1)), 63'd0}) : 64'd0;
      5: return {1'($urandom_range(1)), 63'd0};
      default: return as_dbl ? $realtobits(real'(si) / 4.0) : si;
    endcase
  endfunction

  task send_random();
    logic [2:0]  k;
    logic [1:0]  ta, tb;
    logic [63:0] va, vb;
    k  = ($urandom_range(19) == 0) ? (KIND_BAD_A | 3'($urandom_range(1))) :
                                     3'($urandom_range(5));
    ta = ($urandom_range(19) == 0) ? (trc_pkg::TYPE_OTHER | 2'($urandom_range(1))) :
                                     2'($urandom_range(1));
    tb = ($urandom_range(19) == 0) ? (trc_pkg::TYPE_OTHER | 2'($urandom_range(1))) :
                                     2'($urandom_range(1));
    va = rand_operand(ta == trc_pkg::TYPE_DBL);
    vb = rand_operand(tb == trc_pkg::TYPE_DBL);
    // Often make b close to a so equality and tolerance paths really fire.
    if ($urandom_range(2) == 0) begin
      if (ta == tb) vb = ($urandom_range(1) != 0) ? va : va + 64'($urandom_range(3));
      else if (ta == trc_pkg::TYPE_DBL) vb = longint'($rtoi($bitstoreal(va)));
      else vb = $realtobits(real'($signed(va)));
    end
    send(k, ta, va, tb, vb);
  endtask

  logic [63:0] eps_list [8];

  initial begin
    eps_list[0] = trc_pkg::EPSILON_RESET;
    eps_list[1] = 64'd0;
    eps_list[2] = $realtobits(0.5);
    eps_list[3] = $realtobits(-1.0);
    eps_list[4] = DBL_NAN;
    eps_list[5] = DBL_INF;
    eps_list[6] = 64'hFFFF_FFFF_FFFF_FFFF;
    eps_list[7] = $realtobits(1.0e10);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every operator, saturation, NaN, infinities, errors.
    send(trc_pkg::KIND_EQ, trc_pkg::TYPE_I64, 64'd0, trc_pkg::TYPE_I64, 64'd0);
    send(trc_pkg::KIND_GT, trc_pkg::TYPE_I64, ~trc_pkg::SIGN64,
         trc_pkg::TYPE_I64, trc_pkg::SIGN64);
    send(trc_pkg::KIND_GE, trc_pkg::TYPE_I64, trc_pkg::SIGN64,
         trc_pkg::TYPE_I64, trc_pkg::SIGN64);
    send(trc_pkg::KIND_LT, trc_pkg::TYPE_I64, '1, trc_pkg::TYPE_I64, 64'd0);
    send(trc_pkg::KIND_LE, trc_pkg::TYPE_I64, '1, trc_pkg::TYPE_I64, '1);
    send(trc_pkg::KIND_NE, trc_pkg::TYPE_I64, 64'd5, trc_pkg::TYPE_I64, 64'd5);
    send(trc_pkg::KIND_EQ, trc_pkg::TYPE_I64, ~trc_pkg::SIGN64,
         trc_pkg::TYPE_DBL, DBL_2P63);
    send(trc_pkg::KIND_EQ, trc_pkg::TYPE_I64, trc_pkg::SIGN64,
         trc_pkg::TYPE_DBL, 64'hC3F0_0000_0000_0000);
    send(trc_pkg::KIND_EQ, trc_pkg::TYPE_I64, 64'd0, trc_pkg::TYPE_DBL, DBL_NAN);
    send(trc_pkg::KIND_EQ, trc_pkg::TYPE_I64, '1,
         trc_pkg::TYPE_DBL, $realtobits(-1.75));
    send(trc_pkg::KIND_GT, trc_pkg::TYPE_DBL, DBL_NAN, trc_pkg::TYPE_DBL, 64'd0);
    send(trc_pkg::KIND_LE, trc_pkg::TYPE_DBL, DBL_NAN, trc_pkg::TYPE_DBL, DBL_NAN);
    send(trc_pkg::KIND_EQ, trc_pkg::TYPE_DBL, DBL_NAN, trc_pkg::TYPE_I64, 64'd0);
    send(trc_pkg::KIND_NE, trc_pkg::TYPE_DBL, DBL_NAN, trc_pkg::TYPE_DBL, DBL_NAN);
    send(trc_pkg::KIND_EQ, trc_pkg::TYPE_DBL, DBL_INF, trc_pkg::TYPE_DBL, DBL_INF);
    send(trc_pkg::KIND_NE, trc_pkg::TYPE_DBL, DBL_INF, trc_pkg::TYPE_DBL, DBL_INF);
    send(trc_pkg::KIND_EQ, trc_pkg::TYPE_DBL, $realtobits(9007199254740993.0),
         trc_pkg::TYPE_I64, 64'd9007199254740993);
    send(trc_pkg::KIND_EQ, trc_pkg::TYPE_DBL, $realtobits(1.0),
         trc_pkg::TYPE_DBL, $realtobits(1.0000001));
    send(trc_pkg::KIND_GE, trc_pkg::TYPE_DBL, 64'h8000_0000_0000_0000,
         trc_pkg::TYPE_DBL, 64'd0);
    send(KIND_BAD_A, trc_pkg::TYPE_I64, 64'd0, trc_pkg::TYPE_I64, 64'd0);
    send(KIND_BAD_B, trc_pkg::TYPE_DBL, 64'd0, trc_pkg::TYPE_DBL, 64'd0);
    send(trc_pkg::KIND_EQ, trc_pkg::TYPE_OTHER, 64'd0, trc_pkg::TYPE_I64, 64'd0);
    send(trc_pkg::KIND_EQ, trc_pkg::TYPE_I64, 64'd0, TYPE_BAD, 64'd0);
    send(trc_pkg::KIND_NE, TYPE_BAD, '1, trc_pkg::TYPE_OTHER, '1);

    // Random phases over tolerance settings and idle patterns.
    for (int p = 0; p < 8; p++) begin
      write_epsilon(eps_list[p]);
      if (p < 3) begin
        send_idle_pct = 6;
        recv_idle_pct = 73;
      end else if (p < 6) begin
        send_idle_pct = 73;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Stall the output long enough to back the pipe up into the input.
      if (p == 6) hold_cycles = 300;
      repeat (200) send_random();
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests, %0d results checked, over %0d tolerance settings",
             sent, sb.checked, 8);
    $display("mixed int/double operands, NaN, infinities, saturation and bad codes");
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
